@@ rtl/fcm_pkg.sv @@
// ----------------------------------------------------------------------------
// fcm_pkg: shared types and constants of the field colormap pixel block
// Holds payload structs, the pipeline word and the turn-scaled arctangent table.
// ----------------------------------------------------------------------------
package fcm_pkg;

    localparam int ANGLE_ITERS_DEF = 16;
    localparam int TAB_LEN         = 24;
    localparam int XY_W            = 20;

    localparam logic [15:0] THIRD_TURN = 16'd21845;

    // map modes
    localparam logic [1:0] MODE_BWR  = 2'd0;
    localparam logic [1:0] MODE_HSL  = 2'd1;
    localparam logic [1:0] MODE_GRAY = 2'd2;

    // register indexes
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_LOW  = 2'd1;
    localparam logic [1:0] REG_HIGH = 2'd2;

    // gray ramp outcome
    localparam logic [1:0] GRAY_ZERO = 2'd0;
    localparam logic [1:0] GRAY_FULL = 2'd1;
    localparam logic [1:0] GRAY_DIV  = 2'd2;

    typedef struct packed {
        logic signed [15:0] comp_x;
        logic signed [15:0] comp_y;
        logic signed [15:0] comp_z;
        logic signed [31:0] scalar_sample;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] blue_byte;
        logic [7:0] green_byte;
        logic [7:0] red_byte;
        logic [7:0] alpha_byte;
    } pixel_out_t;

    // word carried through the angle and divide stages
    typedef struct packed {
        logic                   valid;
        logic [1:0]             mode;
        logic signed [15:0]     z;
        logic                   zero_vec;
        logic signed [XY_W-1:0] px;
        logic signed [XY_W-1:0] py;
        logic [31:0]            acc;
        logic [1:0]             gray_sel;
        logic [39:0]            rem;
        logic [31:0]            range;
        logic [7:0]             quo;
    } stage_t;

    function automatic logic [31:0] turn_atan(input int idx);
        logic [31:0] tab [TAB_LEN];
        tab = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
                32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
                32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
                32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
        return tab[idx];
    endfunction

endpackage

@@ rtl/fcm_stage.sv @@
// ----------------------------------------------------------------------------
// fcm_stage: one pipeline stage of angle rotation and ramp division
// Does one vectoring micro-rotation and, in the first eight stages, one quotient bit.
// ----------------------------------------------------------------------------
module fcm_stage #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  fcm_pkg::stage_t d,
    output fcm_pkg::stage_t q
);

    localparam int          K     = (IDX < 8) ? (7 - IDX) : 0;
    localparam logic [31:0] ANGLE = fcm_pkg::turn_atan(IDX);

    fcm_pkg::stage_t q_reg;
    fcm_pkg::stage_t q_next;
    logic signed [fcm_pkg::XY_W-1:0] dx;
    logic signed [fcm_pkg::XY_W-1:0] dy;
    logic [39:0] div_step;

    // rotate toward the x axis and try one quotient bit
    always_comb
    begin
        q_next   = d;
        dx       = d.py >>> IDX;
        dy       = d.px >>> IDX;
        div_step = 40'(d.range) << K;
        if (!d.py[fcm_pkg::XY_W-1])
        begin
            q_next.px  = d.px + dx;
            q_next.py  = d.py - dy;
            q_next.acc = d.acc + ANGLE;
        end
        else
        begin
            q_next.px  = d.px - dx;
            q_next.py  = d.py + dy;
            q_next.acc = d.acc - ANGLE;
        end
        if (IDX < 8 && d.rem >= div_step)
        begin
            q_next.rem    = d.rem - div_step;
            q_next.quo[K] = 1'b1;
        end
    end

    // advance when the pipe moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

@@ rtl/field_colormap_pixel.sv @@
// ----------------------------------------------------------------------------
// field_colormap_pixel: field sample to BGRA pixel colormap
// Diverging blue-white-red, HSL hue wheel from a pipelined arctangent, gray ramp or black.
// ----------------------------------------------------------------------------
//  channel | signals                          | transfer when
//  --------+----------------------------------+----------------------------
//  input   | in_valid, in_ready, in_data      | in_valid & in_ready
//  output  | out_valid, out_ready, out_data   | out_valid & out_ready
//  config  | cfg_valid, cfg_ready, cfg_index, | cfg_valid & cfg_ready
//          | cfg_data                         |
//
// One pixel per cycle while the output is not stalled; the path is the input register,
// one stage per micro-rotation, a multiply stage and the output register.
// The rotation stages also compute the eight gray quotient bits, one per stage.
// Reset clears the valid bits and sets the registers to mode 0, low 0, high 1.0.
// A stall at the output freezes the whole pipe; in_ready drops with it.
// ----------------------------------------------------------------------------
module field_colormap_pixel #(
    parameter int ANGLE_ITERS = fcm_pkg::ANGLE_ITERS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fcm_pkg::pixel_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fcm_pkg::pixel_out_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    logic               en;
    logic [1:0]         mode_reg;
    logic signed [31:0] low_reg;
    logic signed [31:0] high_reg;

    fcm_pkg::stage_t s0_reg;
    fcm_pkg::stage_t s0_next;
    fcm_pkg::stage_t pipe [ANGLE_ITERS+1];

    // multiply stage
    logic        a_valid_reg;
    logic [1:0]  a_mode_reg;
    logic [7:0]  a_bwr_reg [3];
    logic [7:0]  a_gray_reg;
    logic [16:0] a_m1_reg;
    logic [16:0] a_m2_reg;
    logic [1:0]  a_seg_reg [3];
    logic [35:0] a_prod_reg [3];
    logic [7:0]  a_bwr_next [3];
    logic [7:0]  a_gray_next;
    logic [16:0] a_m1_next;
    logic [16:0] a_m2_next;
    logic [1:0]  a_seg_next [3];
    logic [35:0] a_prod_next [3];

    // output stage
    logic                 out_valid_reg;
    logic [1:0]           out_mode_reg;
    fcm_pkg::pixel_out_t  out_data_reg;
    fcm_pkg::pixel_out_t  out_data_next;

    fcm_pkg::stage_t last;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign last      = pipe[ANGLE_ITERS];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= fcm_pkg::MODE_BWR;
            low_reg  <= 32'sd0;
            high_reg <= 32'sd65536;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fcm_pkg::REG_MODE: mode_reg <= cfg_data[1:0];
                fcm_pkg::REG_LOW:  low_reg  <= cfg_data;
                fcm_pkg::REG_HIGH: high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // prepare the rotation and the ramp numerator
    always_comb
    begin
        logic signed [32:0] diff;
        logic signed [32:0] span;
        logic signed [16:0] nx;
        logic signed [16:0] ny;
        diff = {in_data.scalar_sample[31], in_data.scalar_sample} - {low_reg[31], low_reg};
        span = {high_reg[31], high_reg} - {low_reg[31], low_reg};
        nx   = -17'(in_data.comp_x);
        ny   = -17'(in_data.comp_y);
        s0_next          = '0;
        s0_next.valid    = in_valid;
        s0_next.mode     = mode_reg;
        s0_next.z        = in_data.comp_z;
        s0_next.zero_vec = (in_data.comp_x == 16'sd0) && (in_data.comp_y == 16'sd0);
        if (nx < 0)
        begin
            s0_next.px  = fcm_pkg::XY_W'(in_data.comp_x);
            s0_next.py  = fcm_pkg::XY_W'(in_data.comp_y);
            s0_next.acc = 32'h8000_0000;
        end
        else
        begin
            s0_next.px  = fcm_pkg::XY_W'(nx);
            s0_next.py  = fcm_pkg::XY_W'(ny);
            s0_next.acc = 32'h0;
        end
        s0_next.range = span[31:0];
        s0_next.rem   = {diff[31:0], 8'h00} - 40'(diff[31:0]);
        priority if (high_reg <= low_reg || in_data.scalar_sample <= low_reg)
            s0_next.gray_sel = fcm_pkg::GRAY_ZERO;
        else if (in_data.scalar_sample >= high_reg)
            s0_next.gray_sel = fcm_pkg::GRAY_FULL;
        else
            s0_next.gray_sel = fcm_pkg::GRAY_DIV;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
        end
        else if (en)
        begin
            s0_reg <= s0_next;
        end
    end

    assign pipe[0] = s0_reg;

    // rotation and division stages
    for (genvar i = 0; i < ANGLE_ITERS; i++)
    begin : g_stage
        fcm_stage #(.IDX(i)) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (pipe[i]),
            .q     (pipe[i+1])
        );
    end

    // diverging map channel: start byte s, end byte e
    function automatic logic [7:0] bwr_byte(input logic signed [15:0] z,
                                            input logic [7:0] s, input logic [7:0] e);
        logic [22:0] acc;
        if (z[15])
            acc = {s, 15'h0} + 23'(8'(8'd255 - s) * z[14:0]);
        else
            acc = {8'd255, 15'h0} - 23'(8'(8'd255 - e) * z[14:0]);
        return acc[22:15];
    endfunction

    // hue segments, lightness bounds and the interpolation product
    always_comb
    begin
        logic [15:0] hue;
        logic [15:0] lum;
        logic [15:0] frac [3];
        logic [18:0] six;
        logic [18:0] tpos;
        logic [16:0] delta;
        hue   = last.zero_vec ? 16'h8000 : last.acc[31:16];
        lum   = {~last.z[15], last.z[14:0]};
        if (lum <= 16'h8000)
        begin
            a_m1_next = 17'd0;
            a_m2_next = {lum, 1'b0};
        end
        else
        begin
            a_m1_next = {lum, 1'b0} - 17'h10000;
            a_m2_next = 17'h10000;
        end
        delta   = a_m2_next - a_m1_next;
        frac[0] = hue - fcm_pkg::THIRD_TURN;
        frac[1] = hue;
        frac[2] = hue + fcm_pkg::THIRD_TURN;
        for (int c = 0; c < 3; c++)
        begin
            six  = 19'(frac[c]) * 19'd6;
            tpos = 19'h40000 - six;
            priority if (six < 19'h10000)
                a_seg_next[c] = 2'd0;
            else if (frac[c] < 16'h8000)
                a_seg_next[c] = 2'd1;
            else if (six < 19'h40000)
                a_seg_next[c] = 2'd2;
            else
                a_seg_next[c] = 2'd3;
            a_prod_next[c] = 36'(delta) * 36'((a_seg_next[c] == 2'd0) ? six : tpos);
        end
        a_bwr_next[0] = bwr_byte(last.z, 8'hff, 8'h01);
        a_bwr_next[1] = bwr_byte(last.z, 8'h7f, 8'h05);
        a_bwr_next[2] = bwr_byte(last.z, 8'h03, 8'hf4);
        unique case (last.gray_sel)
            fcm_pkg::GRAY_FULL: a_gray_next = 8'd255;
            fcm_pkg::GRAY_DIV:  a_gray_next = last.quo;
            default:            a_gray_next = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mode_reg <= last.mode;
            a_gray_reg <= a_gray_next;
            a_m1_reg   <= a_m1_next;
            a_m2_reg   <= a_m2_next;
            a_bwr_reg  <= a_bwr_next;
            a_seg_reg  <= a_seg_next;
            a_prod_reg <= a_prod_next;
        end
    end

    // scale each hue channel to a byte
    function automatic logic [7:0] hsl_byte(input logic [1:0] seg, input logic [16:0] m1,
                                            input logic [16:0] m2, input logic [35:0] prod);
        logic [33:0] lin;
        logic [41:0] lin255;
        logic [24:0] m255;
        lin = {m1, 16'h0} + prod[33:0];
        lin255 = {lin, 8'h00} - 42'(lin);
        unique case (seg)
            2'd0, 2'd2: return lin255[39:32];
            2'd1:
            begin
                m255 = {m2, 8'h00} - 25'(m2);
                return m255[23:16];
            end
            default:
            begin
                m255 = {m1, 8'h00} - 25'(m1);
                return m255[23:16];
            end
        endcase
    endfunction

    // select the map
    always_comb
    begin
        out_data_next.alpha_byte = 8'hff;
        unique case (a_mode_reg)
            fcm_pkg::MODE_BWR:
            begin
                out_data_next.blue_byte  = a_bwr_reg[0];
                out_data_next.green_byte = a_bwr_reg[1];
                out_data_next.red_byte   = a_bwr_reg[2];
            end
            fcm_pkg::MODE_HSL:
            begin
                out_data_next.blue_byte  = hsl_byte(a_seg_reg[0], a_m1_reg, a_m2_reg,
                                                    a_prod_reg[0]);
                out_data_next.green_byte = hsl_byte(a_seg_reg[1], a_m1_reg, a_m2_reg,
                                                    a_prod_reg[1]);
                out_data_next.red_byte   = hsl_byte(a_seg_reg[2], a_m1_reg, a_m2_reg,
                                                    a_prod_reg[2]);
            end
            fcm_pkg::MODE_GRAY:
            begin
                out_data_next.blue_byte  = a_gray_reg;
                out_data_next.green_byte = a_gray_reg;
                out_data_next.red_byte   = a_gray_reg;
            end
            default:
            begin
                out_data_next.blue_byte  = 8'd0;
                out_data_next.green_byte = 8'd0;
                out_data_next.red_byte   = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_mode_reg <= a_mode_reg;
            out_data_reg <= out_data_next;
        end
    end

    // checks
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.alpha_byte == 8'hff)
        else $error("alpha byte not opaque");

    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_mode_reg == fcm_pkg::MODE_GRAY |->
            out_data.blue_byte == out_data.green_byte &&
            out_data.green_byte == out_data.red_byte)
        else $error("gray channels differ");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(last) && $stable(a_valid_reg))
        else $error("pipeline moved during stall");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for field_colormap_pixel
// Runs a directed table of corner samples, then random phases under each
// mode and ramp setting. An in-bench color predictor checks every pixel in
// order while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_SPARE  = 2'd3;
    localparam logic [1:0] MODE_BLACK = 2'd3;
    localparam int         PIPE_DEPTH = fcm_pkg::ANGLE_ITERS_DEF + 3;
    localparam int         N_PHASES   = 10;
    localparam int         PHASE_LEN  = 74;

    // arctangent per micro-rotation, in 2^-32 turns
    localparam logic [31:0] ROT_ANGLE [16] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] low;
        logic [31:0] high;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [31:0] smp;
        bit          typed;
        logic [7:0]  b;
        logic [7:0]  g;
        logic [7:0]  r;
    } corner_row_t;

    localparam logic [31:0] ONE = 32'h0001_0000;

    corner_row_t corner_rows [22] = '{
        '{fcm_pkg::MODE_BWR, 0, ONE, 16'h0000, 16'h0000, 16'h8000, 32'h0,
          1, 8'hff, 8'h7f, 8'h03},
        '{fcm_pkg::MODE_BWR, 0, ONE, 16'h7fff, 16'h8000, 16'h0000, 32'h0,
          1, 8'hff, 8'hff, 8'hff},
        '{fcm_pkg::MODE_BWR, 0, ONE, 16'h8000, 16'h7fff, 16'h7fff, 32'h0,
          1, 8'h01, 8'h05, 8'hf4},
        '{fcm_pkg::MODE_BWR, 0, ONE, 16'h0000, 16'h0000, 16'hffff, 32'h0,
          0, 8'h0, 8'h0, 8'h0},
        '{fcm_pkg::MODE_BWR, 0, ONE, 16'h0000, 16'h0000, 16'h0001, 32'h0,
          0, 8'h0, 8'h0, 8'h0},
        '{fcm_pkg::MODE_HSL, 0, ONE, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          0, 8'h0, 8'h0, 8'h0},
        '{fcm_pkg::MODE_HSL, 0, ONE, 16'h1234, 16'h8000, 16'h8000, 32'h0,
          1, 8'h00, 8'h00, 8'h00},
        '{fcm_pkg::MODE_HSL, 0, ONE, 16'h7fff, 16'h0000, 16'h0000, 32'h0,
          0, 8'h0, 8'h0, 8'h0},
        '{fcm_pkg::MODE_HSL, 0, ONE, 16'h8000, 16'h0000, 16'h7fff, 32'h0,
          0, 8'h0, 8'h0, 8'h0},
        '{fcm_pkg::MODE_HSL, 0, ONE, 16'h0000, 16'h7fff, 16'h4000, 32'h0,
          0, 8'h0, 8'h0, 8'h0},
        '{fcm_pkg::MODE_HSL, 0, ONE, 16'h0000, 16'h8000, 16'hc000, 32'h0,
          0, 8'h0, 8'h0, 8'h0},
        '{fcm_pkg::MODE_HSL, 0, ONE, 16'h8000, 16'h8000, 16'h0000, 32'h0,
          0, 8'h0, 8'h0, 8'h0},
        '{fcm_pkg::MODE_HSL, 0, ONE, 16'hffff, 16'h0000, 16'h0000, 32'h0,
          0, 8'h0, 8'h0, 8'h0},
        '{fcm_pkg::MODE_HSL, 0, ONE, 16'h8000, 16'hffff, 16'h0000, 32'h0,
          0, 8'h0, 8'h0, 8'h0},
        '{fcm_pkg::MODE_HSL, 0, ONE, 16'h7fff, 16'h7fff, 16'h7fff, 32'h0,
          0, 8'h0, 8'h0, 8'h0},
        '{fcm_pkg::MODE_GRAY, 0, ONE, 16'h0, 16'h0, 16'h0, 32'h8000_0000,
          1, 8'h00, 8'h00, 8'h00},
        '{fcm_pkg::MODE_GRAY, 0, ONE, 16'h0, 16'h0, 16'h0, 32'h7fff_ffff,
          1, 8'hff, 8'hff, 8'hff},
        '{fcm_pkg::MODE_GRAY, 0, ONE, 16'h0, 16'h0, 16'h0, 32'h0000_8000,
          1, 8'h7f, 8'h7f, 8'h7f},
        '{fcm_pkg::MODE_GRAY, 32'h8000_0000, 32'h7fff_ffff, 16'h0, 16'h0, 16'h0, 32'h0,
          0, 8'h0, 8'h0, 8'h0},
        '{fcm_pkg::MODE_GRAY, ONE, ONE, 16'h0, 16'h0, 16'h0, 32'h7fff_ffff,
          1, 8'h00, 8'h00, 8'h00},
        '{fcm_pkg::MODE_GRAY, ONE, 0, 16'h0, 16'h0, 16'h0, 32'h0000_8000,
          1, 8'h00, 8'h00, 8'h00},
        '{MODE_BLACK, 0, ONE, 16'h7fff, 16'h8000, 16'h7fff, 32'h7fff_ffff, 1,
          8'h00, 8'h00, 8'h00}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    fcm_pkg::pixel_in_t   in_data;
    logic                 out_valid;
    logic                 out_ready;
    fcm_pkg::pixel_out_t  out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [31:0]          cfg_data;

    // register copies and pending pixels
    logic [1:0]           map_mode_q;
    logic signed [31:0]   ramp_low_q;
    logic signed [31:0]   ramp_high_q;
    fcm_pkg::pixel_out_t  pending_pixels [$];
    int                   fail_count;
    bit                   long_hold_req;
    bit                   calm_phase;

    field_colormap_pixel uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hue as a 16-bit fraction of a turn: angle of (-x,-y)
    function automatic longint hue_turn(longint x, longint y);
        longint      px;
        longint      py;
        longint      dx;
        longint      dy;
        logic [31:0] acc;
        px  = -x;
        py  = -y;
        acc = 32'h0;
        if (x == 0 && y == 0)
            return 32768;
        if (px < 0)
        begin
            px  = -px;
            py  = -py;
            acc = 32'h8000_0000;
        end
        for (int i = 0; i < fcm_pkg::ANGLE_ITERS_DEF; i++)
        begin
            dx = py >>> i;
            dy = px >>> i;
            if (py >= 0)
            begin
                px  = px + dx;
                py  = py - dy;
                acc = acc + ROT_ANGLE[i];
            end
            else
            begin
                px  = px - dx;
                py  = py + dy;
                acc = acc - ROT_ANGLE[i];
            end
        end
        return longint'(acc[31:16]);
    endfunction

    function automatic logic [7:0] hsl_byte(longint m1, longint m2, longint f);
        longint h;
        longint v;
        h = f & 64'hFFFF;
        if (6 * h < 65536)
            v = (255 * (m1 * 65536 + (m2 - m1) * 6 * h)) >>> 32;
        else if (h < 32768)
            v = (255 * m2) >>> 16;
        else if (3 * h < 131072)
            v = (255 * (m1 * 65536 + (m2 - m1) * (262144 - 6 * h))) >>> 32;
        else
            v = (255 * m1) >>> 16;
        return v[7:0];
    endfunction

    function automatic logic [7:0] diverging_byte(longint z, longint s, longint e);
        longint v;
        if (z < 0)
            v = (s * 32768 + (255 - s) * (z + 32768)) >>> 15;
        else
            v = (255 * 32768 - (255 - e) * z) >>> 15;
        return v[7:0];
    endfunction

    function automatic fcm_pkg::pixel_out_t color_of(fcm_pkg::pixel_in_t p);
        fcm_pkg::pixel_out_t c;
        longint     z;
        longint     h;
        longint     l;
        longint     m1;
        longint     m2;
        longint     lo;
        longint     hi;
        longint     s;
        longint     gray;
        z = longint'(p.comp_z);
        c = '{8'h00, 8'h00, 8'h00, 8'hff};
        case (map_mode_q)
            fcm_pkg::MODE_BWR:
            begin
                c.blue_byte  = diverging_byte(z, 8'hff, 8'h01);
                c.green_byte = diverging_byte(z, 8'h7f, 8'h05);
                c.red_byte   = diverging_byte(z, 8'h03, 8'hf4);
            end
            fcm_pkg::MODE_HSL:
            begin
                h = hue_turn(longint'(p.comp_x), longint'(p.comp_y));
                l = z + 32768;
                if (l <= 32768)
                begin
                    m1 = 0;
                    m2 = 2 * l;
                end
                else
                begin
                    m1 = 2 * l - 65536;
                    m2 = 65536;
                end
                c.red_byte   = hsl_byte(m1, m2, h + fcm_pkg::THIRD_TURN);
                c.green_byte = hsl_byte(m1, m2, h);
                c.blue_byte  = hsl_byte(m1, m2, h + 65536 - fcm_pkg::THIRD_TURN);
            end
            fcm_pkg::MODE_GRAY:
            begin
                lo   = longint'(ramp_low_q);
                hi   = longint'(ramp_high_q);
                s    = longint'(p.scalar_sample);
                gray = 0;
                if (hi > lo)
                begin
                    if (s >= hi)
                        gray = 255;
                    else if (s > lo)
                        gray = (255 * (s - lo)) / (hi - lo);
                end
                c.blue_byte  = gray[7:0];
                c.green_byte = gray[7:0];
                c.red_byte   = gray[7:0];
            end
            default:
            begin
            end
        endcase
        return c;
    endfunction

    function automatic int idle_len();
        int pick;
        if (calm_phase)
            return 0;
        pick = $urandom_range(99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // offer one sample and record its color on transfer
    task automatic send_pixel(fcm_pkg::pixel_in_t p);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (!in_ready);
        pending_pixels.push_back(color_of(p));
    endtask

    // drain the pipe, then write mode, ramp ends and the spare index
    task automatic set_registers(logic [1:0] mode, logic [31:0] low, logic [31:0] high);
        logic [1:0]  idx [4];
        logic [31:0] val [4];
        in_valid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
        idx = '{fcm_pkg::REG_MODE, fcm_pkg::REG_LOW, fcm_pkg::REG_HIGH, REG_SPARE};
        val = '{{30'($urandom), mode}, low, high, $urandom};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[i])
                fcm_pkg::REG_MODE: map_mode_q  = val[i][1:0];
                fcm_pkg::REG_LOW:  ramp_low_q  = val[i];
                fcm_pkg::REG_HIGH: ramp_high_q = val[i];
                default:
                begin
                end
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(3)) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_sample();
        longint span;
        case ($urandom_range(5))
            0:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            1:       return $urandom;
            2:       return ramp_low_q + 32'($urandom_range(2)) - 32'd1;
            3:       return ramp_high_q + 32'($urandom_range(2)) - 32'd1;
            default:
            begin
                span = longint'(ramp_high_q) - longint'(ramp_low_q);
                if (span <= 0)
                    return $urandom;
                return 32'(longint'(ramp_low_q) + ({$urandom, $urandom} % span));
            end
        endcase
    endfunction

    // stimulus
    initial
    begin
        fcm_pkg::pixel_in_t p;
        logic [1:0]  mode;
        logic [31:0] low;
        logic [31:0] high;
        in_valid      <= 1'b0;
        in_data       <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= fcm_pkg::REG_MODE;
        cfg_data      <= '0;
        map_mode_q    = fcm_pkg::MODE_BWR;
        ramp_low_q    = 32'sh0;
        ramp_high_q   = 32'sh0001_0000;
        long_hold_req = 1'b0;
        calm_phase    = 1'b0;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the corner table, rewriting registers when a row asks
        foreach (corner_rows[i])
        begin
            if (corner_rows[i].mode != map_mode_q || corner_rows[i].low != ramp_low_q
                || corner_rows[i].high != ramp_high_q)
                set_registers(corner_rows[i].mode, corner_rows[i].low, corner_rows[i].high);
            p = '{corner_rows[i].x, corner_rows[i].y, corner_rows[i].z, corner_rows[i].smp};
            if (corner_rows[i].typed)
            begin
                if (color_of(p) != {corner_rows[i].b, corner_rows[i].g, corner_rows[i].r,
                                    8'hff})
                begin
                    $error("corner row %0d: table color %h disagrees with predictor %h",
                           i, {corner_rows[i].b, corner_rows[i].g, corner_rows[i].r},
                           color_of(p));
                    fail_count++;
                end
            end
            send_pixel(p);
        end

        // random phases over modes and ramp settings
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            mode = (ph == 7) ? MODE_BLACK : 2'(ph % 3);
            case (ph % 5)
                0: begin low = 32'h8000_0000; high = 32'h7fff_ffff; end
                1: begin low = $urandom; high = low; end
                2: begin low = $urandom; high = $urandom; end
                3: begin low = 32'($urandom_range(4000)) - 32'd2000;
                         high = low + 32'($urandom_range(300)); end
                default: begin low = 32'h7fff_ffff; high = 32'h8000_0000; end
            endcase
            set_registers(mode, low, high);
            calm_phase = (ph == 4);
            if (ph == 1)
                long_hold_req = 1'b1;
            for (int k = 0; k < PHASE_LEN; k++)
            begin
                p.comp_x        = rand_comp();
                p.comp_y        = rand_comp();
                p.comp_z        = rand_comp();
                p.scalar_sample = rand_sample();
                send_pixel(p);
            end
        end
        in_valid <= 1'b0;

        // drain and settle
        wait (pending_pixels.size() == 0);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // output stalls, with one long hold-off on request
    initial
    begin
        int n;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                n = $urandom_range(12, 1);
                repeat (n) @(posedge clk);
                n = idle_len();
                if (n > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    // check each output transfer against the oldest pending color
    initial
    begin
        fcm_pkg::pixel_out_t want;
        fail_count = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("unexpected pixel %h", out_data);
                    fail_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (out_data.blue_byte != want.blue_byte)
                    begin
                        $error("blue_byte: expected %0d, got %0d",
                               want.blue_byte, out_data.blue_byte);
                        fail_count++;
                    end
                    if (out_data.green_byte != want.green_byte)
                    begin
                        $error("green_byte: expected %0d, got %0d",
                               want.green_byte, out_data.green_byte);
                        fail_count++;
                    end
                    if (out_data.red_byte != want.red_byte)
                    begin
                        $error("red_byte: expected %0d, got %0d",
                               want.red_byte, out_data.red_byte);
                        fail_count++;
                    end
                    if (out_data.alpha_byte != want.alpha_byte)
                    begin
                        $error("alpha_byte: expected %0d, got %0d",
                               want.alpha_byte, out_data.alpha_byte);
                        fail_count++;
                    end
                end
            end
        end
    end

    // hard stop for a hung run
    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
